/* hw/rtl/gll_pkg.sv */
// gll_pkg: shared constants, item and saturation types and helpers for the
// Gaussian log-likelihood scorer. No dependencies.
package gll_pkg;

    localparam int MAX_DIM     = 64;
    localparam int ADDR_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PEND_MAX    = QUEUE_DEPTH + 2;     // queue, work slot, result reg
    localparam int PEND_W      = $clog2(PEND_MAX + 2);

    localparam int DIFF_W  = 17;  // Q8.8 difference
    localparam int PROD_W  = 33;  // 16 x 17 product
    localparam int ACC_W   = 48;  // saturated accumulators
    localparam int SAT_W   = 55;  // pre-saturation sums
    localparam int QSUM_W  = 66;  // term * diff + rounding
    localparam int Q_W     = 54;  // QSUM_W - 12
    localparam int PLO_W   = 42;  // 25 x 17
    localparam int PHI_W   = 41;  // 24 x 17
    localparam int SPLIT   = 24;  // term split point for the two half multiplies

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // front-end classification of one item
    typedef enum logic [1:0] {
        K_SKIP,      // off-diagonal in diagonal mode
        K_OFFD,      // off-diagonal, full mode
        K_DIAG,      // diagonal, row sum ignored
        K_DIAG_ROW   // diagonal, row sum added
    } t_kind;

    typedef struct packed {
        logic                    first;
        logic signed [31:0]      offset;
        logic [5:0]              column;
        t_kind                   kind;
        logic signed [DIFF_W-1:0] diff;
        logic signed [15:0]      prec;
        logic                    last;
    } t_item;

    typedef struct packed {
        logic                    ovf;
        logic signed [ACC_W-1:0] val;
    } t_sat;

    function automatic t_sat sat_acc(input logic signed [SAT_W-1:0] v);
        t_sat s;
        if (v[SAT_W-1:ACC_W-1] == {(SAT_W-ACC_W+1){v[SAT_W-1]}}) begin
            s.ovf = 1'b0;
            s.val = v[ACC_W-1:0];
        end else begin
            s.ovf = 1'b1;
            s.val = v[SAT_W-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

endpackage

/* hw/rtl/gll_in_if.sv */
// gll_in_if: valid/ready channel carrying one precision-entry item.
// No dependencies.
interface gll_in_if;
    logic               valid;
    logic               ready;
    logic               first_item;
    logic signed [31:0] offset;
    logic [5:0]         column;
    logic               is_diagonal;
    logic signed [15:0] feature_value;
    logic signed [15:0] mean_value;
    logic signed [15:0] precision_value;
    logic               last_item;

    modport source (
        output valid, first_item, offset, column, is_diagonal,
               feature_value, mean_value, precision_value, last_item,
        input  ready
    );
    modport sink (
        input  valid, first_item, offset, column, is_diagonal,
               feature_value, mean_value, precision_value, last_item,
        output ready
    );
endinterface

/* hw/rtl/gll_out_if.sv */
// gll_out_if: valid/ready channel carrying one score result item.
// No dependencies.
interface gll_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] log_likelihood;
    logic               saturated;

    modport source (output valid, log_likelihood, saturated, input ready);
    modport sink   (input  valid, log_likelihood, saturated, output ready);
endinterface

/* hw/rtl/gll_ram.sv */
// gll_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module gll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/gll_front.sv */
// gll_front: accepts items, holds the mode register, forms the difference,
// classifies each item and queues it. Depends on gll_pkg and gll_in_if.
module gll_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    gll_in_if.sink          i_item,
    input  logic            i_pop,
    output logic            o_head_valid,
    output gll_pkg::t_item  o_head
);

    localparam logic [gll_pkg::QPTR_W-1:0] PTR_LAST = gll_pkg::QPTR_W'(gll_pkg::QUEUE_DEPTH - 1);
    localparam logic [gll_pkg::QCNT_W-1:0] CNT_FULL = gll_pkg::QCNT_W'(gll_pkg::QUEUE_DEPTH);

    logic                        r_full_mode;
    gll_pkg::t_item              r_queue [gll_pkg::QUEUE_DEPTH];
    logic [gll_pkg::QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [gll_pkg::QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [gll_pkg::QCNT_W-1:0]  r_count,  n_count;
    logic                        push;
    gll_pkg::t_item              n_entry;

    assign i_item.ready = (r_count != CNT_FULL);
    assign push         = i_item.valid && i_item.ready;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_queue[r_rd_ptr];

    always_comb begin
        n_entry.first  = i_item.first_item;
        n_entry.offset = i_item.offset;
        n_entry.column = i_item.column;
        n_entry.diff   = gll_pkg::DIFF_W'(i_item.feature_value)
                       - gll_pkg::DIFF_W'(i_item.mean_value);
        n_entry.prec   = i_item.precision_value;
        n_entry.last   = i_item.last_item;
        if (i_item.is_diagonal) begin
            n_entry.kind = r_full_mode ? gll_pkg::K_DIAG_ROW : gll_pkg::K_DIAG;
        end else begin
            n_entry.kind = r_full_mode ? gll_pkg::K_OFFD : gll_pkg::K_SKIP;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_mode <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_full_mode <= i_cfg_wdata;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= n_entry;
        end
    end

endmodule

/* hw/rtl/gll_back.sv */
// gll_back: sequencer that pops classified items, runs the multiply and
// accumulate steps, keeps the difference RAM and drives the result register.
// Depends on gll_pkg, gll_out_if and gll_ram.
module gll_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  gll_pkg::t_item  i_head,
    output logic            o_pop,
    gll_out_if.source       o_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_MUL,
        ST_QSUM,
        ST_TOTAL,
        ST_OMUL,
        ST_ROW,
        ST_OUT
    } t_state;

    t_state                               r_state, n_state;
    logic signed [gll_pkg::ACC_W-1:0]     r_row,   n_row;
    logic signed [gll_pkg::ACC_W-1:0]     r_total, n_total;
    logic                                 r_ovf,   n_ovf;
    logic signed [gll_pkg::PROD_W-1:0]    r_p,     n_p;
    logic signed [gll_pkg::ACC_W-1:0]     r_term,  n_term;
    logic signed [gll_pkg::PLO_W-1:0]     r_plo,   n_plo;
    logic signed [gll_pkg::PHI_W-1:0]     r_phi,   n_phi;
    logic signed [gll_pkg::Q_W-1:0]       r_q,     n_q;
    logic signed [gll_pkg::DIFF_W-1:0]    r_diff,  n_diff;
    logic signed [15:0]                   r_prec,  n_prec;
    logic                                 r_last,  n_last;
    logic                                 r_use_row, n_use_row;
    logic                                 r_in_range, n_in_range;
    logic                                 r_out_valid, n_out_valid;
    logic signed [gll_pkg::ACC_W-1:0]     r_out_ll,  n_out_ll;
    logic                                 r_out_sat, n_out_sat;

    logic                                 in_range;
    logic                                 head_is_diag;
    logic                                 ram_we;
    logic [gll_pkg::ADDR_W-1:0]           ram_addr;
    logic [gll_pkg::DIFF_W-1:0]           ram_rdata;
    logic signed [gll_pkg::DIFF_W-1:0]    stored_diff;
    logic signed [gll_pkg::PROD_W-1:0]    head_p;
    logic signed [gll_pkg::PROD_W-1:0]    off_p;
    logic signed [gll_pkg::SAT_W-1:0]     row_part;
    logic signed [gll_pkg::QSUM_W-1:0]    qsum;
    logic signed [gll_pkg::ACC_W-1:0]     neg_val;
    logic                                 neg_ovf;
    gll_pkg::t_sat                        term_sat, total_sat, row_sat;

    assign in_range     = (int'(i_head.column) < gll_pkg::MAX_DIM);
    assign head_is_diag = (i_head.kind == gll_pkg::K_DIAG)
                       || (i_head.kind == gll_pkg::K_DIAG_ROW);
    assign o_pop        = (r_state == ST_IDLE) && i_head_valid;
    assign ram_we       = o_pop && head_is_diag && in_range;
    assign ram_addr     = gll_pkg::ADDR_W'(i_head.column);

    gll_ram #(
        .WIDTH (gll_pkg::DIFF_W),
        .DEPTH (gll_pkg::MAX_DIM)
    ) u_diff_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (i_head.diff),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // datapath
    assign head_p      = $signed(i_head.prec) * $signed(i_head.diff);
    assign stored_diff = r_in_range ? $signed(ram_rdata) : '0;
    assign off_p       = r_prec * stored_diff;
    assign row_part    = r_use_row ? gll_pkg::SAT_W'(r_row) : '0;
    assign term_sat    = gll_pkg::sat_acc(gll_pkg::SAT_W'(r_p >>> 1) + row_part);
    // round half up, then drop 12 fraction bits (Q.28 to Q.16)
    assign qsum        = (gll_pkg::QSUM_W'(r_phi) <<< gll_pkg::SPLIT)
                       + gll_pkg::QSUM_W'(r_plo) + gll_pkg::QSUM_W'(2048);
    assign total_sat   = gll_pkg::sat_acc(gll_pkg::SAT_W'(r_total) + gll_pkg::SAT_W'(r_q));
    assign row_sat     = gll_pkg::sat_acc(gll_pkg::SAT_W'(r_row) + gll_pkg::SAT_W'(r_p));
    assign neg_ovf     = (r_total == gll_pkg::ACC_MIN);
    assign neg_val     = neg_ovf ? gll_pkg::ACC_MAX : -r_total;

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_p         = r_p;
        n_term      = r_term;
        n_plo       = r_plo;
        n_phi       = r_phi;
        n_q         = r_q;
        n_diff      = r_diff;
        n_prec      = r_prec;
        n_last      = r_last;
        n_use_row   = r_use_row;
        n_in_range  = r_in_range;
        n_out_valid = r_out_valid;
        n_out_ll    = r_out_ll;
        n_out_sat   = r_out_sat;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    n_diff     = i_head.diff;
                    n_prec     = i_head.prec;
                    n_last     = i_head.last;
                    n_use_row  = (i_head.kind == gll_pkg::K_DIAG_ROW);
                    n_in_range = in_range;
                    n_p        = head_p;
                    if (i_head.first) begin
                        n_row   = '0;
                        n_ovf   = 1'b0;
                        n_total = gll_pkg::ACC_W'(i_head.offset);
                    end
                    unique case (i_head.kind)
                        gll_pkg::K_DIAG,
                        gll_pkg::K_DIAG_ROW: n_state = ST_TERM;
                        gll_pkg::K_OFFD:     n_state = ST_OMUL;
                        gll_pkg::K_SKIP:     n_state = i_head.last ? ST_OUT : ST_IDLE;
                    endcase
                end
            end
            ST_TERM: begin
                n_term = term_sat.val;
                if (term_sat.ovf) begin
                    n_ovf = 1'b1;
                end
                n_state = ST_MUL;
            end
            ST_MUL: begin
                // term * diff as two half-width products
                n_plo   = $signed({1'b0, r_term[gll_pkg::SPLIT-1:0]}) * r_diff;
                n_phi   = $signed(r_term[gll_pkg::ACC_W-1:gll_pkg::SPLIT]) * r_diff;
                n_state = ST_QSUM;
            end
            ST_QSUM: begin
                n_q     = qsum[gll_pkg::QSUM_W-1:gll_pkg::QSUM_W-gll_pkg::Q_W];
                n_state = ST_TOTAL;
            end
            ST_TOTAL: begin
                n_total = total_sat.val;
                if (total_sat.ovf) begin
                    n_ovf = 1'b1;
                end
                n_row   = '0;
                n_state = r_last ? ST_OUT : ST_IDLE;
            end
            ST_OMUL: begin
                n_p     = off_p;
                n_state = ST_ROW;
            end
            ST_ROW: begin
                n_row = row_sat.val;
                if (row_sat.ovf) begin
                    n_ovf = 1'b1;
                end
                n_state = r_last ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ll    = neg_val;
                    n_out_sat   = r_ovf || neg_ovf;
                    n_ovf       = r_ovf || neg_ovf;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_p         <= '0;
            r_term      <= '0;
            r_plo       <= '0;
            r_phi       <= '0;
            r_q         <= '0;
            r_diff      <= '0;
            r_prec      <= '0;
            r_last      <= 1'b0;
            r_use_row   <= 1'b0;
            r_in_range  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_ll    <= '0;
            r_out_sat   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_p         <= n_p;
            r_term      <= n_term;
            r_plo       <= n_plo;
            r_phi       <= n_phi;
            r_q         <= n_q;
            r_diff      <= n_diff;
            r_prec      <= n_prec;
            r_last      <= n_last;
            r_use_row   <= n_use_row;
            r_in_range  <= n_in_range;
            r_out_valid <= n_out_valid;
            r_out_ll    <= n_out_ll;
            r_out_sat   <= n_out_sat;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.log_likelihood = r_out_ll;
    assign o_result.saturated      = r_out_sat;

endmodule

/* hw/rtl/gaussian_log_likelihood_top.sv */
// Gaussian log-likelihood scorer, top level: front queue plus back sequencer.
// Back sequencer per item: diagonal goes through pop, term, multiply, sum and total states,
// off-diagonal (full mode) through pop, multiply and row, ignored only through pop; a last
// item adds the state that loads the result register (it waits there while a result is held).
// The back sequencer takes a new item only when idle again; the 2-entry queue keeps accepting
// meanwhile. A last item reaches result valid via the queue, the work states and the result reg.
// Reset (i_rst_n low, synchronous) clears queue, sums, flags, mode; difference RAM is not cleared.
module gaussian_log_likelihood_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,      // full_rank_mode write strobe
    input  logic      i_cfg_wdata,   // full_rank_mode value
    gll_in_if.sink    i_item,
    gll_out_if.source o_result
);

    // Front classifies items against the mode register: diagonal with or
    // without the row sum, off-diagonal, or ignored (off-diagonal in
    // diagonal mode). The difference feature - mean is formed here so the
    // back can start its first multiply on the pop cycle.
    logic            head_valid;
    logic            pop;
    gll_pkg::t_item  head;

    gll_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item       (i_item),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Back: diagonal items run p = prec*d, term = sat(p/2 [+ row, full mode]),
    // term*d in two half products, rounding, then total update. Off-diagonal
    // items read the stored difference and add prec*d to the row sum. A last
    // item ends in the negate-and-saturate step that loads the result register.
    gll_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_result     (o_result)
    );

endmodule

/* hw/rtl/gll_checker.sv */
// gll_checker: port-level assertions for the scorer, bound to the top level.
// Depends on gll_pkg and gaussian_log_likelihood_top (bind target).
module gll_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [47:0] i_out_ll,
    input logic        i_out_sat
);

    logic [gll_pkg::PEND_W-1:0] r_pending;
    logic                       in_last_acc;
    logic                       out_acc;

    assign in_last_acc = i_in_valid && i_in_ready && i_in_last;
    assign out_acc     = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_last_acc && !out_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_acc && !in_last_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_result_has_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != '0))
        else $error("result without a pending last item");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= gll_pkg::PEND_W'(gll_pkg::PEND_MAX))
        else $error("more last items in flight than the pipeline holds");

    a_neg_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_ll != gll_pkg::ACC_MIN))
        else $error("negated score reached the negative limit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_ll)
                                        && $stable(i_out_sat))
        else $error("stalled result changed");

endmodule

bind gaussian_log_likelihood_top gll_checker u_gll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_last   (i_item.last_item),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_ll    (o_result.log_likelihood),
    .i_out_sat   (o_result.saturated)
);
